// ----- src/noc_pkg.sv -----
// ----------------------------------------------------------------------------
// Nearest occupied cell search: shared types and constants
// Word layouts for both channels, the register map and the internal stage
// records passed between the pipeline modules.
// ----------------------------------------------------------------------------
package noc_pkg;

    localparam int unsigned COORD_W    = 24;
    localparam int unsigned CELL_W     = 8;
    localparam int unsigned SIZE_W     = 16;
    localparam int unsigned RANGE_W    = 23;
    localparam int unsigned GRID_W     = 11;
    localparam int unsigned ACC_W      = 26;
    localparam int unsigned SUM_W      = 28;
    localparam int unsigned DIFF_W     = 25;
    localparam int unsigned SQ_W       = 49;
    localparam int unsigned DIST_W     = 52;
    localparam int unsigned LIM_W      = 46;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [CFG_ADDR_W-1:0] REG_BASE_X       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BASE_Y       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_SIZE    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VISION_RANGE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GRID_WIDTH   = 3'd4;

    typedef struct packed {
        logic signed [COORD_W-1:0] pose_x;
        logic signed [COORD_W-1:0] pose_y;
        logic signed [CELL_W-1:0]  cell_value;
        logic                      last_cell;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] obstacle_x;
        logic signed [COORD_W-1:0] obstacle_y;
        logic                      found;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] base_x;
        logic signed [COORD_W-1:0] base_y;
        logic [SIZE_W-1:0]         cell_size;
        logic [RANGE_W-1:0]        vision_range;
        logic [GRID_W-1:0]         grid_width;
    } t_cfg;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic                      occupied;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
    } t_stage1;

    typedef struct packed {
        logic                      valid;
        logic                      last;
        logic                      occupied;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [SQ_W-1:0]           sq_x;
        logic [SQ_W-1:0]           sq_y;
    } t_stage2;

endpackage

// ----- src/nearest_occupied_cell_search.sv -----
// ----------------------------------------------------------------------------
// Nearest occupied cell search
// Grid cells arrive in raster order on the input channel, one word per cycle
// when not stalled, each word carrying the query position, the cell value and
// a last-cell flag. The block tracks the nearest occupied cell whose centre
// lies strictly inside the vision range and, for the word flagged as the last
// cell, sends one result word: the best centre with found set, or zero with
// found clear. A new input word is accepted in every cycle that is not
// stalled. The pipeline has three register stages (cell centre, squared
// offsets, running minimum); a last cell passes through the centre register,
// the squared offset register and then the result register.
// The running minimum compare and the raster offset counters are loop-carried.
// Input stall is raised only when a last cell reaches the minimum stage while
// an earlier result is still held on a stalled output; ordinary cells keep
// flowing while a result waits. Reset clears the scan, the pipeline and the
// output valid, and returns the registers to origin zero, cell size 256,
// vision range 2560 and grid width one. The user must write registers
// via the plain write port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module nearest_occupied_cell_search #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  noc_pkg::t_in_word                  i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output noc_pkg::t_out_word                 o_out_word,
    input  logic                               i_cfg_we,
    input  logic [noc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [noc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    noc_pkg::t_cfg    r_cfg;
    noc_pkg::t_stage1 stage1;
    noc_pkg::t_stage2 stage2;
    logic             hold;
    logic             adv;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_x       <= '0;
            r_cfg.base_y       <= '0;
            r_cfg.cell_size    <= 16'd256;
            r_cfg.vision_range <= 23'd2560;
            r_cfg.grid_width   <= 11'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                noc_pkg::REG_BASE_X: begin
                    r_cfg.base_x <= i_cfg_data[noc_pkg::COORD_W-1:0];
                end
                noc_pkg::REG_BASE_Y: begin
                    r_cfg.base_y <= i_cfg_data[noc_pkg::COORD_W-1:0];
                end
                noc_pkg::REG_CELL_SIZE: begin
                    r_cfg.cell_size <= i_cfg_data[noc_pkg::SIZE_W-1:0];
                end
                noc_pkg::REG_VISION_RANGE: begin
                    r_cfg.vision_range <= i_cfg_data[noc_pkg::RANGE_W-1:0];
                end
                noc_pkg::REG_GRID_WIDTH: begin
                    r_cfg.grid_width <= i_cfg_data[noc_pkg::GRID_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign hold       = stage2.valid && stage2.last && o_out_valid && i_out_stall;
    assign adv        = !hold;
    assign accept     = i_in_valid && adv;
    assign o_in_stall = hold;

    noc_centre #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_centre (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_accept (accept),
        .i_word   (i_in_word),
        .i_cfg    (r_cfg),
        .o_stage  (stage1)
    );

    noc_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_stage (stage1),
        .o_stage (stage2)
    );

    noc_select u_select (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_stage        (stage2),
        .i_vision_range (r_cfg.vision_range),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_out_word     (o_out_word)
    );

endmodule

// ----- src/noc_centre.sv -----
// ----------------------------------------------------------------------------
// Cell centre stage
// Keeps the raster column and row offsets and registers the saturated centre
// of each accepted cell together with the query position.
// ----------------------------------------------------------------------------
module noc_centre #(
    parameter int unsigned MAX_WIDTH = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic              i_accept,
    input  noc_pkg::t_in_word i_word,
    input  noc_pkg::t_cfg     i_cfg,
    output noc_pkg::t_stage1  o_stage
);

    localparam int unsigned CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned WW = ((CW > noc_pkg::GRID_W) ? CW : noc_pkg::GRID_W) + 1;

    logic [CW-1:0]                    r_column;
    logic [noc_pkg::ACC_W-1:0]        r_acc_x;
    logic [noc_pkg::ACC_W-1:0]        r_acc_y;
    noc_pkg::t_stage1                 r_stage;

    logic signed [noc_pkg::SUM_W-1:0] half_ext;
    logic signed [noc_pkg::SUM_W-1:0] sum_x;
    logic signed [noc_pkg::SUM_W-1:0] sum_y;
    logic [WW-1:0]                    w_raw;
    logic [WW-1:0]                    w_max;
    logic [WW-1:0]                    w_eff;
    logic [WW-1:0]                    col_next;
    logic                             row_wrap;
    logic [noc_pkg::ACC_W-1:0]        size_ext;

    function automatic logic signed [noc_pkg::COORD_W-1:0] sat_coord(
        input logic signed [noc_pkg::SUM_W-1:0] v
    );
        logic signed [noc_pkg::SUM_W-1:0] hi;
        logic signed [noc_pkg::SUM_W-1:0] lo;
        hi = {{(noc_pkg::SUM_W-noc_pkg::COORD_W+1){1'b0}}, {(noc_pkg::COORD_W-1){1'b1}}};
        lo = {{(noc_pkg::SUM_W-noc_pkg::COORD_W+1){1'b1}}, {(noc_pkg::COORD_W-1){1'b0}}};
        priority if (v > hi) begin
            return hi[noc_pkg::COORD_W-1:0];
        end else if (v < lo) begin
            return lo[noc_pkg::COORD_W-1:0];
        end else begin
            return v[noc_pkg::COORD_W-1:0];
        end
    endfunction

    always_comb begin
        half_ext = {{(noc_pkg::SUM_W-noc_pkg::SIZE_W+1){1'b0}},
                    i_cfg.cell_size[noc_pkg::SIZE_W-1:1]};
        sum_x = {{(noc_pkg::SUM_W-noc_pkg::COORD_W){i_cfg.base_x[noc_pkg::COORD_W-1]}},
                 i_cfg.base_x}
              + {{(noc_pkg::SUM_W-noc_pkg::ACC_W){1'b0}}, r_acc_x} + half_ext;
        sum_y = {{(noc_pkg::SUM_W-noc_pkg::COORD_W){i_cfg.base_y[noc_pkg::COORD_W-1]}},
                 i_cfg.base_y}
              + {{(noc_pkg::SUM_W-noc_pkg::ACC_W){1'b0}}, r_acc_y} + half_ext;

        w_raw = {{(WW-noc_pkg::GRID_W){1'b0}}, i_cfg.grid_width};
        w_max = WW'(MAX_WIDTH);
        priority if (w_raw == '0) begin
            w_eff = {{(WW-1){1'b0}}, 1'b1};
        end else if (w_raw > w_max) begin
            w_eff = w_max;
        end else begin
            w_eff = w_raw;
        end
        col_next = {{(WW-CW){1'b0}}, r_column} + {{(WW-1){1'b0}}, 1'b1};
        row_wrap = !(col_next < w_eff);
        size_ext = {{(noc_pkg::ACC_W-noc_pkg::SIZE_W){1'b0}}, i_cfg.cell_size};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column      <= '0;
            r_acc_x       <= '0;
            r_acc_y       <= '0;
            r_stage.valid <= 1'b0;
        end else begin
            if (i_accept) begin
                if (i_word.last_cell) begin
                    r_column <= '0;
                    r_acc_x  <= '0;
                    r_acc_y  <= '0;
                end else if (!row_wrap) begin
                    r_column <= col_next[CW-1:0];
                    r_acc_x  <= r_acc_x + size_ext;
                end else begin
                    r_column <= '0;
                    r_acc_x  <= '0;
                    r_acc_y  <= r_acc_y + size_ext;
                end
            end
            if (i_adv) begin
                r_stage.valid    <= i_accept;
                r_stage.last     <= i_word.last_cell;
                r_stage.occupied <= (i_word.cell_value > 8'sd0);
                r_stage.cx       <= sat_coord(sum_x);
                r_stage.cy       <= sat_coord(sum_y);
                r_stage.px       <= i_word.pose_x;
                r_stage.py       <= i_word.pose_y;
            end
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- src/noc_dist.sv -----
// ----------------------------------------------------------------------------
// Squared offset stage
// Forms the x and y offsets from the query position and registers their
// squares.
// ----------------------------------------------------------------------------
module noc_dist (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_adv,
    input  noc_pkg::t_stage1 i_stage,
    output noc_pkg::t_stage2 o_stage
);

    noc_pkg::t_stage2                    r_stage;
    logic signed [noc_pkg::DIFF_W-1:0]   dx;
    logic signed [noc_pkg::DIFF_W-1:0]   dy;
    logic signed [2*noc_pkg::DIFF_W-1:0] prod_x;
    logic signed [2*noc_pkg::DIFF_W-1:0] prod_y;

    always_comb begin
        dx = {i_stage.cx[noc_pkg::COORD_W-1], i_stage.cx}
           - {i_stage.px[noc_pkg::COORD_W-1], i_stage.px};
        dy = {i_stage.cy[noc_pkg::COORD_W-1], i_stage.cy}
           - {i_stage.py[noc_pkg::COORD_W-1], i_stage.py};
        prod_x = dx * dx;
        prod_y = dy * dy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage.valid    <= i_stage.valid;
            r_stage.last     <= i_stage.last;
            r_stage.occupied <= i_stage.occupied;
            r_stage.cx       <= i_stage.cx;
            r_stage.cy       <= i_stage.cy;
            r_stage.sq_x     <= prod_x[noc_pkg::SQ_W-1:0];
            r_stage.sq_y     <= prod_y[noc_pkg::SQ_W-1:0];
        end
    end

    assign o_stage = r_stage;

endmodule

// ----- src/noc_select.sv -----
// ----------------------------------------------------------------------------
// Nearest cell selection and result register
// Keeps the running minimum over the scan and presents one result word per
// scan on the output channel.
// ----------------------------------------------------------------------------
module noc_select (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  noc_pkg::t_stage2              i_stage,
    input  logic [noc_pkg::RANGE_W-1:0]   i_vision_range,
    input  logic                          i_out_stall,
    output logic                          o_out_valid,
    output noc_pkg::t_out_word            o_out_word
);

    logic [noc_pkg::LIM_W-1:0]        r_lim;
    logic [noc_pkg::DIST_W-1:0]       r_best;
    logic signed [noc_pkg::COORD_W-1:0] r_best_x;
    logic signed [noc_pkg::COORD_W-1:0] r_best_y;
    logic                             r_any;
    logic                             r_out_valid;
    noc_pkg::t_out_word               r_out_word;

    logic [noc_pkg::DIST_W-1:0]       dist_sq;
    logic                             take;

    always_comb begin
        dist_sq = {{(noc_pkg::DIST_W-noc_pkg::SQ_W){1'b0}}, i_stage.sq_x}
                + {{(noc_pkg::DIST_W-noc_pkg::SQ_W){1'b0}}, i_stage.sq_y};
        take = i_stage.valid && i_stage.occupied
            && (dist_sq < {{(noc_pkg::DIST_W-noc_pkg::LIM_W){1'b0}}, r_lim})
            && (dist_sq < r_best);
    end

    always_ff @(posedge i_clk) begin
        r_lim <= i_vision_range * i_vision_range;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '1;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_any       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv && i_stage.valid) begin
                if (i_stage.last) begin
                    r_best   <= '1;
                    r_best_x <= '0;
                    r_best_y <= '0;
                    r_any    <= 1'b0;
                end else if (take) begin
                    r_best   <= dist_sq;
                    r_best_x <= i_stage.cx;
                    r_best_y <= i_stage.cy;
                    r_any    <= 1'b1;
                end
            end
            if (i_adv && i_stage.valid && i_stage.last) begin
                r_out_valid           <= 1'b1;
                r_out_word.obstacle_x <= take ? i_stage.cx : r_best_x;
                r_out_word.obstacle_y <= take ? i_stage.cy : r_best_y;
                r_out_word.found      <= take || r_any;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

// ----- src/noc_checker.sv -----
// ----------------------------------------------------------------------------
// Nearest occupied cell search: port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module noc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_stall,
    input noc_pkg::t_in_word              i_in_word,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input noc_pkg::t_out_word             o_out_word
);

    // A result word waiting on a stalled receiver stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word changed while stalled");

    // A stalled input word stays put.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_word))
        else $error("input word changed while stalled");

    // No result word is shown in the cycle after reset.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Input is only held back by a full, stalled output.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a blocked result");

    // Without a hit the reported centre is zero.
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.found |->
            o_out_word.obstacle_x == '0 && o_out_word.obstacle_y == '0)
        else $error("non-zero centre reported without a hit");

endmodule

bind nearest_occupied_cell_search noc_checker u_noc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_word   (i_in_word),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

// ----- sim/nearest_occupied_cell_search_tb.sv -----
// ----------------------------------------------------------------------------
// Nearest occupied cell search testbench
// Streams occupancy grid scans into the block through the valid/stall input
// channel and checks every result word against a cycle-free predictor of the
// nearest occupied cell centre. Directed scans cover the default registers,
// raster-order ties, the strict range bound, a zero range, saturated centres,
// far poses, row offset wrap-around and register writes in the middle of a
// scan. Random scans with random registers, occupancy and idle gaps on both
// channels follow.
// ----------------------------------------------------------------------------
module nearest_occupied_cell_search_tb;

    localparam int unsigned COORD_W      = noc_pkg::COORD_W;
    localparam int unsigned CELL_W       = noc_pkg::CELL_W;
    localparam int unsigned SIZE_W       = noc_pkg::SIZE_W;
    localparam int unsigned RANGE_W      = noc_pkg::RANGE_W;
    localparam int unsigned GRID_W       = noc_pkg::GRID_W;
    localparam int unsigned ACC_W        = noc_pkg::ACC_W;
    localparam int unsigned DIST_W       = noc_pkg::DIST_W;
    localparam int unsigned CFG_ADDR_W   = noc_pkg::CFG_ADDR_W;
    localparam int unsigned CFG_DATA_W   = noc_pkg::CFG_DATA_W;
    localparam int unsigned MAX_WIDTH    = 1024;
    localparam int unsigned RANDOM_CELLS = 150;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam longint     COORD_MAX    = 64'sd8388607;
    localparam longint     COORD_MIN    = -64'sd8388608;

    logic                  i_clk    = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    noc_pkg::t_in_word     in_word  = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_stall;
    logic                  out_valid;
    noc_pkg::t_out_word    out_word;

    noc_pkg::t_cfg             grid_cfg;
    logic [9:0]                scan_column;
    logic [ACC_W-1:0]          scan_x_off;
    logic [ACC_W-1:0]          scan_y_off;
    logic [DIST_W-1:0]         nearest_dist_sq;
    logic signed [COORD_W-1:0] nearest_x;
    logic signed [COORD_W-1:0] nearest_y;
    logic                      nearest_valid;
    noc_pkg::t_out_word        pending_obstacles[$];

    bit          sender_idles = 1'b1;
    bit          sink_stalls  = 1'b1;
    int unsigned mismatches   = 0;

    nearest_occupied_cell_search #(
        .MAX_WIDTH (MAX_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_scan();
        scan_column     = '0;
        scan_x_off      = '0;
        scan_y_off      = '0;
        nearest_dist_sq = '1;
        nearest_x       = '0;
        nearest_y       = '0;
        nearest_valid   = 1'b0;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
        if (v > COORD_MAX) return COORD_MAX[COORD_W-1:0];
        if (v < COORD_MIN) return COORD_MIN[COORD_W-1:0];
        return v[COORD_W-1:0];
    endfunction

    function automatic void track_nearest(input noc_pkg::t_in_word w);
        longint                    half;
        longint                    width;
        longint                    dx;
        longint                    dy;
        longint                    dist_sq;
        longint                    reach;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        noc_pkg::t_out_word        hit;
        half  = longint'(grid_cfg.cell_size >> 1);
        width = longint'(grid_cfg.grid_width);
        if (width == 0) width = 1;
        if (width > MAX_WIDTH) width = MAX_WIDTH;
        if ($signed(w.cell_value) > 0) begin
            cx = clamp_coord(longint'($signed(grid_cfg.base_x))
                             + longint'(scan_x_off) + half);
            cy = clamp_coord(longint'($signed(grid_cfg.base_y))
                             + longint'(scan_y_off) + half);
            dx = longint'(cx) - longint'($signed(w.pose_x));
            dy = longint'(cy) - longint'($signed(w.pose_y));
            dist_sq = dx * dx + dy * dy;
            reach   = longint'(grid_cfg.vision_range) * longint'(grid_cfg.vision_range);
            if (dist_sq < reach && dist_sq < longint'(nearest_dist_sq)) begin
                nearest_dist_sq = dist_sq[DIST_W-1:0];
                nearest_x       = cx;
                nearest_y       = cy;
                nearest_valid   = 1'b1;
            end
        end
        if (w.last_cell) begin
            hit.obstacle_x = nearest_valid ? nearest_x : '0;
            hit.obstacle_y = nearest_valid ? nearest_y : '0;
            hit.found      = nearest_valid;
            pending_obstacles.insert(pending_obstacles.size(), hit);
            clear_scan();
        end else if (longint'(scan_column) + 1 < width) begin
            scan_column = scan_column + 1'b1;
            scan_x_off  = scan_x_off + grid_cfg.cell_size;
        end else begin
            scan_column = '0;
            scan_x_off  = '0;
            scan_y_off  = scan_y_off + grid_cfg.cell_size;
        end
    endfunction

    function automatic noc_pkg::t_in_word cell_word(
        input logic signed [COORD_W-1:0] px,
        input logic signed [COORD_W-1:0] py,
        input logic signed [CELL_W-1:0]  value,
        input logic                      last
    );
        noc_pkg::t_in_word w;
        w.pose_x     = px;
        w.pose_y     = py;
        w.cell_value = value;
        w.last_cell  = last;
        return w;
    endfunction

    function automatic logic signed [COORD_W-1:0] pose_near(
        input logic signed [COORD_W-1:0] base
    );
        int unsigned cs;
        cs = 32'(grid_cfg.cell_size);
        return base + COORD_W'($urandom_range(0, 8 * cs)) - COORD_W'(cs);
    endfunction

    task automatic send_cell(input noc_pkg::t_in_word w);
        int unsigned gap;
        gap = sender_idles ? $urandom_range(0, 14) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        track_nearest(w);
    endtask

    task automatic hold_input();
        @(negedge i_clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        hold_input();
        while (pending_obstacles.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= data;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        unique case (addr)
            noc_pkg::REG_BASE_X:       grid_cfg.base_x       = data[COORD_W-1:0];
            noc_pkg::REG_BASE_Y:       grid_cfg.base_y       = data[COORD_W-1:0];
            noc_pkg::REG_CELL_SIZE:    grid_cfg.cell_size    = data[SIZE_W-1:0];
            noc_pkg::REG_VISION_RANGE: grid_cfg.vision_range = data[RANGE_W-1:0];
            noc_pkg::REG_GRID_WIDTH:   grid_cfg.grid_width   = data[GRID_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic signed [COORD_W-1:0] ox,
                              input logic signed [COORD_W-1:0] oy,
                              input logic [SIZE_W-1:0]         cs,
                              input logic [RANGE_W-1:0]        vr,
                              input logic [GRID_W-1:0]         gw);
        wait_drained();
        write_reg(noc_pkg::REG_BASE_X, ox);
        write_reg(noc_pkg::REG_BASE_Y, oy);
        write_reg(noc_pkg::REG_CELL_SIZE, CFG_DATA_W'(cs));
        write_reg(noc_pkg::REG_VISION_RANGE, CFG_DATA_W'(vr));
        write_reg(noc_pkg::REG_GRID_WIDTH, CFG_DATA_W'(gw));
    endtask

    task automatic run_scan(input int unsigned               cells,
                            input int unsigned               quiet,
                            input int unsigned               occ_pct,
                            input logic signed [COORD_W-1:0] px,
                            input logic signed [COORD_W-1:0] py,
                            input bit                        wander);
        logic signed [CELL_W-1:0] value;
        for (int unsigned i = 0; i < cells; i++) begin
            if ($urandom_range(0, 99) < ((i < quiet) ? 2 : occ_pct))
                value = CELL_W'($urandom_range(1, 127));
            else if ($urandom_range(0, 3) == 0)
                value = CELL_W'($urandom());
            else
                value = CELL_W'(-int'($urandom_range(0, 128)));
            if (wander && $urandom_range(0, 3) == 0) begin
                px = pose_near(grid_cfg.base_x);
                py = pose_near(grid_cfg.base_y);
            end
            send_cell(cell_word(px, py, value, i == cells - 1));
        end
    endtask

    task automatic test_reset_defaults();
        send_cell(cell_word(0, 0, 0, 1'b0));
        send_cell(cell_word(0, 0, -128, 1'b0));
        send_cell(cell_word(0, 0, 127, 1'b1));
        send_cell(cell_word(0, 0, 0, 1'b1));
        send_cell(cell_word(-8388608, 8388607, 1, 1'b1));
    endtask

    task automatic test_tie_and_bound();
        set_config(0, 0, 256, 2560, 2);
        send_cell(cell_word(256, 128, 5, 1'b0));
        send_cell(cell_word(256, 128, 9, 1'b1));
        send_cell(cell_word(2688, 128, 1, 1'b1));
        send_cell(cell_word(2687, 128, 1, 1'b1));
    endtask

    task automatic test_zero_range();
        set_config(0, 0, 256, 0, 1);
        send_cell(cell_word(128, 128, 127, 1'b1));
    endtask

    task automatic test_extreme_coords();
        set_config(8388607, -8388608, 65535, 8388607, 0);
        send_cell(cell_word(8388607, -8388608, 127, 1'b0));
        send_cell(cell_word(8388607, -8388608, -1, 1'b0));
        send_cell(cell_word(8388607, -8388608, 1, 1'b1));
        send_cell(cell_word(-8388608, 8388607, 127, 1'b1));
    endtask

    task automatic test_config_mid_scan();
        set_config(0, 0, 256, 2560, 3);
        send_cell(cell_word(300, 200, 0, 1'b0));
        send_cell(cell_word(300, 200, 5, 1'b0));
        set_config(100, -50, 64, 5000, 2);
        send_cell(cell_word(300, 200, 7, 1'b0));
        send_cell(cell_word(300, 200, 3, 1'b0));
        send_cell(cell_word(300, 200, 1, 1'b1));
    endtask

    task automatic test_row_wrap();
        set_config(0, -8388608, 65535, 8388607, 1);
        run_scan(1030, 1020, 50, 32767, -8291330, 1'b0);
    endtask

    task automatic test_random_scans();
        int unsigned               sent;
        int unsigned               phase_end;
        int unsigned               cells;
        int unsigned               cs;
        int unsigned               mode;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] oy;
        logic [RANGE_W-1:0]        vr;
        logic [GRID_W-1:0]         gw;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        sent = 0;
        while (sent < RANDOM_CELLS) begin
            cs = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                             : $urandom_range(16, 512);
            ox = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom())
                                             : COORD_W'($urandom_range(0, 8192) - 4096);
            oy = ($urandom_range(0, 3) == 0) ? COORD_W'($urandom())
                                             : COORD_W'($urandom_range(0, 8192) - 4096);
            vr = RANGE_W'(($urandom_range(0, 7) == 0) ? 0 :
                          ($urandom_range(0, 6) == 0) ? 8388607 :
                          cs * $urandom_range(1, 6));
            gw = GRID_W'(($urandom_range(0, 7) == 0) ? 0 :
                         ($urandom_range(0, 6) == 0) ? $urandom_range(1, 2047) :
                         $urandom_range(1, 8));
            set_config(ox, oy, SIZE_W'(cs), vr, gw);
            mode = $urandom_range(0, 3);
            sender_idles = (mode != 0) && ($urandom_range(0, 3) != 0);
            sink_stalls  = (mode != 0) && ($urandom_range(0, 3) != 0);
            phase_end = sent + $urandom_range(60, 160);
            while (sent < phase_end) begin
                cells = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 40);
                if ($urandom_range(0, 4) == 0) begin
                    px = COORD_W'($urandom());
                    py = COORD_W'($urandom());
                end else begin
                    px = pose_near(grid_cfg.base_x);
                    py = pose_near(grid_cfg.base_y);
                end
                run_scan(cells, 0, $urandom_range(5, 60), px, py, $urandom_range(0, 6) == 0);
                sent += cells;
                if ($urandom_range(0, 15) == 0) wait_drained();
            end
        end
    endtask

    initial begin : obstacle_sink
        int unsigned        hold;
        noc_pkg::t_out_word want;
        wait (rst_n === 1'b1);
        forever begin
            hold = sink_stalls ? $urandom_range(0, 14) : 0;
            if (hold > 0) begin
                @(negedge i_clk);
                out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
                out_stall <= 1'b0;
            end
            @(posedge i_clk);
            while (out_valid !== 1'b1) @(posedge i_clk);
            if (pending_obstacles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: x=%0d y=%0d found=%0b",
                             out_word.obstacle_x, out_word.obstacle_y, out_word.found);
            end else begin
                want = pending_obstacles.pop_front();
                if (out_word.obstacle_x !== want.obstacle_x ||
                    out_word.obstacle_y !== want.obstacle_y ||
                    out_word.found !== want.found) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"obstacle mismatch: expected x=%0d y=%0d found=%0b,",
                                  " got x=%0d y=%0d found=%0b"},
                                 want.obstacle_x, want.obstacle_y, want.found,
                                 out_word.obstacle_x, out_word.obstacle_y, out_word.found);
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("nearest_occupied_cell_search_tb: FAIL");
        $finish;
    end

    initial begin : main
        grid_cfg.base_x       = '0;
        grid_cfg.base_y       = '0;
        grid_cfg.cell_size    = 16'd256;
        grid_cfg.vision_range = 23'd2560;
        grid_cfg.grid_width   = 11'd1;
        clear_scan();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_tie_and_bound();
        test_zero_range();
        test_extreme_coords();
        test_config_mid_scan();
        test_row_wrap();
        test_random_scans();
        wait_drained();
        if (mismatches == 0) begin
            $display("nearest_occupied_cell_search_tb: PASS");
        end else begin
            $display("nearest_occupied_cell_search_tb: FAIL");
        end
        $finish;
    end

endmodule
